// ===== sv/gprd_pkg.sv =====
// ----------------------------------------------------------------------------
// gprd_pkg
// Shared types, codes and microcode table for the gamepad report delta encoder.
// ----------------------------------------------------------------------------
package gprd_pkg;

	localparam int NUM_BUTTONS_DEF = 11;
	localparam int KEY_SLOTS       = 11;
	localparam int AXES            = 8;
	localparam int STEPS           = KEY_SLOTS + AXES + 1;
	localparam int STEP_W          = $clog2(STEPS);
	localparam int SEL_W           = $clog2(KEY_SLOTS);
	localparam int AX_W            = $clog2(AXES);

	localparam int IN_DATA_W  = 112;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USER_W = 2;

	localparam logic [STEP_W-1:0] STEP_ABS0 = STEP_W'(KEY_SLOTS);

	localparam logic [1:0] KIND_SYNC = 2'd0;
	localparam logic [1:0] KIND_KEY  = 2'd1;
	localparam logic [1:0] KIND_ABS  = 2'd2;

	localparam logic [9:0] KEY_CODES [KEY_SLOTS] = '{
		10'd304, 10'd305, 10'd307, 10'd308, 10'd310, 10'd311,
		10'd314, 10'd315, 10'd316, 10'd317, 10'd318
	};

	// lx, ly, rx, ry, lt, rt, hat x, hat y
	localparam logic [9:0] AXIS_CODES [AXES] = '{
		10'd0, 10'd1, 10'd3, 10'd4, 10'd2, 10'd5, 10'd16, 10'd17
	};

	typedef enum logic [1:0] {
		OP_KEY  = 2'd0,
		OP_ABS  = 2'd1,
		OP_SYNC = 2'd2
	} op_t;

	// one control word: jmp sends a key step beyond the button count to STEP_ABS0
	typedef struct packed {
		op_t              op;
		logic [9:0]       code;
		logic [SEL_W-1:0] sel;
		logic             jmp;
	} uop_t;

	typedef struct packed {
		logic load;
		logic emit;
		logic commit;
		uop_t uop;
	} seq_ctl_t;

	typedef struct packed {
		logic changed;
		logic out_free;
	} dp_sts_t;

	function automatic uop_t gprd_ucode(input logic [STEP_W-1:0] step);
		uop_t             w;
		logic [STEP_W-1:0] rel;
		rel = step - STEP_ABS0;
		w.op   = OP_SYNC;
		w.code = 10'd0;
		w.sel  = '0;
		w.jmp  = 1'b0;
		if (step < STEP_ABS0) begin
			w.op   = OP_KEY;
			w.sel  = step[SEL_W-1:0];
			w.code = KEY_CODES[step[SEL_W-1:0]];
			w.jmp  = 1'b1;
		end else if (step < STEP_W'(STEPS - 1)) begin
			w.op   = OP_ABS;
			w.sel  = SEL_W'(rel[AX_W-1:0]);
			w.code = AXIS_CODES[rel[AX_W-1:0]];
		end
		return w;
	endfunction

endpackage

// ===== sv/gprd_seq.sv =====
// ----------------------------------------------------------------------------
// gprd_seq
// Step counter and microcode table; one control word per step.
// ----------------------------------------------------------------------------
module gprd_seq #(
	parameter int NUM_BUTTONS = gprd_pkg::NUM_BUTTONS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gprd_pkg::dp_sts_t   sts,
	output gprd_pkg::seq_ctl_t  ctl
);
	import gprd_pkg::*;

	localparam int NBTN = (NUM_BUTTONS < KEY_SLOTS) ? NUM_BUTTONS : KEY_SLOTS;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	uop_t              uop;
	logic              skip;
	logic              want;
	logic              advance;

	always_comb begin
		uop     = gprd_ucode(step_q);
		skip    = uop.jmp && (uop.sel >= SEL_W'(NBTN));
		want    = (uop.op == OP_SYNC) || (sts.changed && !skip);
		advance = busy_q && (!want || sts.out_free);
	end

	assign in_ready   = !busy_q;
	assign ctl.load   = in_valid && !busy_q;
	assign ctl.emit   = busy_q && want && sts.out_free;
	assign ctl.commit = ctl.emit && (uop.op == OP_SYNC);
	assign ctl.uop    = uop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (ctl.load) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (advance) begin
			if (uop.op == OP_SYNC) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end else if (skip) begin
				step_q <= STEP_ABS0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

// ===== sv/gprd_dp.sv =====
// ----------------------------------------------------------------------------
// gprd_dp
// Report registers, change compare and event output register.
// ----------------------------------------------------------------------------
module gprd_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [gprd_pkg::IN_DATA_W-1:0]      in_data,
	input  logic [gprd_pkg::IN_USER_W-1:0]      in_user,
	input  gprd_pkg::seq_ctl_t                  ctl,
	output gprd_pkg::dp_sts_t                   sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [gprd_pkg::OUT_DATA_W-1:0]     out_data,
	output logic [gprd_pkg::OUT_USER_W-1:0]     out_user,
	output logic                                out_last
);
	import gprd_pkg::*;

	logic [KEY_SLOTS-1:0] new_btn_q;
	logic [KEY_SLOTS-1:0] prev_btn_q;
	logic [15:0]          new_ax_q  [AXES];
	logic [15:0]          prev_ax_q [AXES];
	logic [15:0]          in_ax     [AXES];
	logic                 end_req;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [9:0]  code_q;
	logic [15:0] value_q;
	logic        last_q;

	logic        key_new;
	logic [15:0] ax_new;

	always_comb begin
		end_req  = in_user[0];
		in_ax[0] = in_data[26:11];
		in_ax[1] = in_data[42:27];
		in_ax[2] = in_data[58:43];
		in_ax[3] = in_data[74:59];
		in_ax[4] = {8'd0, in_data[82:75]};
		in_ax[5] = {8'd0, in_data[90:83]};
		in_ax[6] = {{8{in_data[98]}}, in_data[98:91]};
		in_ax[7] = {{8{in_data[106]}}, in_data[106:99]};
	end

	always_comb begin
		key_new = new_btn_q[ctl.uop.sel];
		ax_new  = new_ax_q[ctl.uop.sel[AX_W-1:0]];
		case (ctl.uop.op)
			OP_KEY:  sts.changed = key_new != prev_btn_q[ctl.uop.sel];
			OP_ABS:  sts.changed = ax_new != prev_ax_q[ctl.uop.sel[AX_W-1:0]];
			default: sts.changed = 1'b1;
		endcase
		sts.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			new_btn_q <= end_req ? '0 : in_data[10:0];
			for (int i = 0; i < AXES; i++)
				new_ax_q[i] <= end_req ? 16'd0 : in_ax[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_btn_q <= '0;
			for (int i = 0; i < AXES; i++)
				prev_ax_q[i] <= 16'd0;
		end else if (ctl.commit) begin
			prev_btn_q <= new_btn_q;
			for (int i = 0; i < AXES; i++)
				prev_ax_q[i] <= new_ax_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			case (ctl.uop.op)
				OP_KEY: begin
					kind_q  <= KIND_KEY;
					code_q  <= ctl.uop.code;
					value_q <= {15'd0, key_new};
					last_q  <= 1'b0;
				end
				OP_ABS: begin
					kind_q  <= KIND_ABS;
					code_q  <= ctl.uop.code;
					value_q <= ax_new;
					last_q  <= 1'b0;
				end
				default: begin
					kind_q  <= KIND_SYNC;
					code_q  <= 10'd0;
					value_q <= 16'd0;
					last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {6'd0, value_q, code_q};
	assign out_user  = kind_q;
	assign out_last  = last_q;

endmodule

// ===== sv/gamepad_report_delta_events.sv =====
// ----------------------------------------------------------------------------
// gamepad_report_delta_events
// Emits one event per changed control of a gamepad report, then a sync event.
// ----------------------------------------------------------------------------
// Order: each request runs 20 microcode steps (11 button, 8 axis, 1 sync), one
//   per cycle while the output is free; each emitted event is registered in the
//   output register, and the closing sync event ends the run. A new request is
//   accepted only once the sync step has left the sequencer idle. Below 11
//   buttons one jump step skips the rest. Output stalls hold the step counter.
// Reset: arst_n clears the stored report to all zeros and idles the sequencer.
module gamepad_report_delta_events #(
	parameter int NUM_BUTTONS = gprd_pkg::NUM_BUTTONS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// buttons, left_x, left_y, right_x, right_y, left_trigger, right_trigger,
	// hat_horizontal, hat_vertical, zero pad
	input  logic [gprd_pkg::IN_DATA_W-1:0]   s_tdata,
	// req_type
	input  logic [gprd_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// event_code, event_value, zero pad
	output logic [gprd_pkg::OUT_DATA_W-1:0]  m_tdata,
	// event_kind
	output logic [gprd_pkg::OUT_USER_W-1:0]  m_tuser,
	// last_of_run
	output logic                             m_tlast
);
	import gprd_pkg::*;

	seq_ctl_t ctl;
	dp_sts_t  sts;

	gprd_seq #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	gprd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.ctl       (ctl),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("sequencer not busy after request");

	a_last_is_sync: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_SYNC && m_tdata == '0)
		else $error("closing event is not a clean sync");

	a_idle_after_sync: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> s_tready)
		else $error("sequencer still busy after sync");

	a_no_emit_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !ctl.emit)
		else $error("event emitted while idle");

endmodule

// ===== tb/sv/gamepad_report_delta_events_test.sv =====
// ----------------------------------------------------------------------------
// gamepad_report_delta_events_test
// Streams gamepad reports and end requests into the delta encoder, predicts the
// key, axis and sync events of each request from a mirrored copy of the stored
// report, and checks every event field as it leaves, under random bursts,
// receiver stalls, a long receiver hold and a full drain pause.
// ----------------------------------------------------------------------------
module gamepad_report_delta_events_test;

	import gprd_pkg::*;

	localparam int BUTTON_COUNT   = NUM_BUTTONS_DEF;
	localparam int HOLD_CYCLES    = 250;
	localparam int SETTLE_CYCLES  = 30;
	localparam int WATCHDOG_LIMIT = 3000;

	localparam logic REQ_REPORT = 1'b0;
	localparam logic REQ_END    = 1'b1;

	// A, B, X, Y, LB, RB, Back, Start, Guide, L3, R3 (index 0 = A)
	localparam logic [10:0][9:0] BUTTON_EVENT_CODES = {
		10'd318, 10'd317, 10'd316, 10'd315, 10'd314, 10'd311,
		10'd310, 10'd308, 10'd307, 10'd305, 10'd304
	};
	// lx, ly, rx, ry, lt, rt, hat x, hat y (index 0 = lx)
	localparam logic [7:0][9:0] AXIS_EVENT_CODES = {
		10'd17, 10'd16, 10'd5, 10'd2, 10'd4, 10'd3, 10'd1, 10'd0
	};

	typedef struct packed {
		logic [1:0][7:0]  hat;
		logic [1:0][7:0]  trig;
		logic [3:0][15:0] stick;
		logic [10:0]      buttons;
	} report_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  code;
		logic [15:0] value;
		logic        last;
	} pad_event_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  m_tlast;

	report_t    held_report;
	pad_event_t expected_events[$];
	pad_event_t want;
	int         errors;
	int         burst_left;
	int         quiet_cycles;
	bit         hold_sink;
	int         sink_mode;
	int         sink_left;
	int         sink_phase;

	gamepad_report_delta_events #(
		.NUM_BUTTONS(BUTTON_COUNT)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic push_event(input logic [1:0] kind, input logic [9:0] code,
			input logic [15:0] value, input logic last);
		pad_event_t ev;
		ev.kind  = kind;
		ev.code  = code;
		ev.value = value;
		ev.last  = last;
		expected_events.push_back(ev);
	endtask

	task automatic predict_delta_events(input logic req, input report_t rpt);
		report_t nxt;
		nxt = (req == REQ_END) ? '0 : rpt;
		for (int i = 0; i < BUTTON_COUNT && i < 11; i++)
			if (held_report.buttons[i] != nxt.buttons[i])
				push_event(KIND_KEY, BUTTON_EVENT_CODES[i], {15'd0, nxt.buttons[i]}, 1'b0);
		for (int i = 0; i < 4; i++)
			if (held_report.stick[i] != nxt.stick[i])
				push_event(KIND_ABS, AXIS_EVENT_CODES[i], nxt.stick[i], 1'b0);
		for (int i = 0; i < 2; i++)
			if (held_report.trig[i] != nxt.trig[i])
				push_event(KIND_ABS, AXIS_EVENT_CODES[4 + i], {8'd0, nxt.trig[i]}, 1'b0);
		for (int i = 0; i < 2; i++)
			if (held_report.hat[i] != nxt.hat[i])
				push_event(KIND_ABS, AXIS_EVENT_CODES[6 + i],
					{{8{nxt.hat[i][7]}}, nxt.hat[i]}, 1'b0);
		push_event(KIND_SYNC, 10'd0, 16'd0, 1'b1);
		held_report = nxt;
	endtask

	// entered and left at a falling edge
	task automatic send_request(input logic req, input report_t rpt);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, rpt};
		s_tuser  <= req;
		do @(posedge clk); while (!s_tready);
		predict_delta_events(req, rpt);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		while (expected_events.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [15:0] random_axis();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] random_hat();
		if ($urandom_range(0, 5) == 0)
			return 8'($urandom);
		return 8'($signed($urandom_range(0, 2)) - 1);
	endfunction

	function automatic report_t random_report();
		report_t r;
		r.buttons = 11'($urandom);
		for (int i = 0; i < 4; i++) r.stick[i] = random_axis();
		for (int i = 0; i < 2; i++) r.trig[i] = 8'($urandom);
		for (int i = 0; i < 2; i++) r.hat[i] = random_hat();
		return r;
	endfunction

	// mostly small moves from the held report, like a real pad
	function automatic report_t next_report(input report_t base);
		report_t r;
		int      pick;
		r    = base;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			r = random_report();
		end else if (pick > 1) begin
			r.buttons ^= 11'($urandom & $urandom & $urandom);
			for (int i = 0; i < 4; i++)
				if ($urandom_range(0, 2) == 0) r.stick[i] = random_axis();
			for (int i = 0; i < 2; i++)
				if ($urandom_range(0, 3) == 0) r.trig[i] = 8'($urandom);
			for (int i = 0; i < 2; i++)
				if ($urandom_range(0, 3) == 0) r.hat[i] = random_hat();
		end
		return r;
	endfunction

	task automatic test_directed();
		report_t r;
		r = '0;
		send_request(REQ_REPORT, r);
		r.buttons = 11'h7FF;
		r.stick   = {4{16'h7FFF}};
		r.trig    = {2{8'hFF}};
		r.hat     = {2{8'h7F}};
		send_request(REQ_REPORT, r);
		send_request(REQ_REPORT, r);
		r.buttons = 11'h000;
		r.stick   = {4{16'h8000}};
		r.trig    = {2{8'h00}};
		r.hat     = {2{8'h80}};
		send_request(REQ_REPORT, r);
		send_request(REQ_END, random_report());
		send_request(REQ_END, random_report());
		r         = '0;
		r.hat[0]  = 8'hFF;
		r.hat[1]  = 8'h01;
		send_request(REQ_REPORT, r);
		for (int i = 0; i < 11; i++) begin
			r.buttons = 11'(1 << i);
			send_request(REQ_REPORT, r);
		end
		r.trig[0] = 8'd1;
		r.stick[2] = 16'hFFFF;
		send_request(REQ_REPORT, r);
		send_request(REQ_END, '0);
		wait_for_results();
	endtask

	task automatic test_random_reports(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 11) == 0)
				send_request(REQ_END, random_report());
			else
				send_request(REQ_REPORT, next_report(held_report));
		end
	endtask

	task automatic test_sender_pause();
		for (int n = 0; n < 5; n++) send_request(REQ_REPORT, next_report(held_report));
		wait_for_results();
		for (int n = 0; n < 5; n++) send_request(REQ_REPORT, next_report(held_report));
	endtask

	task automatic test_receiver_hold();
		hold_sink = 1'b1;
		burst_left = 20;
		for (int n = 0; n < 20; n++) send_request(REQ_REPORT, random_report());
		wait_for_results();
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		held_report = '0;
		errors     = 0;
		burst_left = 0;
		hold_sink  = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_reports(150);
		test_sender_pause();
		test_receiver_hold();
		test_random_reports(150);
		wait_for_results();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// receiver: segments of always ready, coin flip, mostly stalled, periodic
	initial begin
		m_tready   = 1'b0;
		sink_left  = 0;
		sink_phase = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_sink = 1'b0;
			end else begin
				if (sink_left == 0) begin
					sink_mode = $urandom_range(0, 3);
					sink_left = $urandom_range(10, 150);
				end
				sink_left--;
				sink_phase++;
				case (sink_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (sink_phase % 3 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_events.size() == 0) begin
				report_error($sformatf("event kind %0d code %0d with no request pending",
					m_tuser, m_tdata[9:0]));
			end else begin
				want = expected_events.pop_front();
				if (m_tuser != want.kind)
					report_error($sformatf("kind %0d, want %0d", m_tuser, want.kind));
				if (m_tdata[9:0] != want.code)
					report_error($sformatf("code %0d, want %0d", m_tdata[9:0], want.code));
				if (m_tdata[25:10] != want.value)
					report_error($sformatf("value %h, want %h (code %0d)",
						m_tdata[25:10], want.value, want.code));
				if (m_tlast != want.last)
					report_error($sformatf("last %0b, want %0b (code %0d)",
						m_tlast, want.last, want.code));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule
